@@ src/adc_frame_deframer_sign_extend_top_defines.svh @@
// ----------------------------------------------------------------------------
// adc frame deframer assertion macros
// shared concurrent check forms, clocked on clk with arst_n as disable
// ----------------------------------------------------------------------------
`ifndef ADC_FRAME_DEFRAMER_SIGN_EXTEND_TOP_DEFINES_SVH
`define ADC_FRAME_DEFRAMER_SIGN_EXTEND_TOP_DEFINES_SVH

// same-cycle implication
`define AFD_CHECK(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("afd check failed");

// next-cycle implication
`define AFD_CHECK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("afd next-cycle check failed");

`endif

@@ src/afd_pkg.sv @@
// ----------------------------------------------------------------------------
// afd_pkg
// frame layout constants and result types for the converter frame deframer
// ----------------------------------------------------------------------------
package afd_pkg;

	localparam int CHANNELS_PER_DEVICE = 8;
	localparam int STATUS_BYTES = 3;
	localparam int SAMPLE_BYTES = 3;
	localparam int SECTION_BYTES = STATUS_BYTES + SAMPLE_BYTES * CHANNELS_PER_DEVICE;
	localparam int OFF_W = $clog2(SECTION_BYTES);
	localparam int CH_W = (CHANNELS_PER_DEVICE > 1) ? $clog2(CHANNELS_PER_DEVICE) : 1;

	// byte phase inside one sample
	typedef logic [1:0] phase_t;
	localparam phase_t PH_HIGH = 2'd0;
	localparam phase_t PH_MID = 2'd1;
	localparam phase_t PH_LOW = 2'd2;

	localparam logic [3:0] LAST_SINGLE = 4'(CHANNELS_PER_DEVICE - 1);
	localparam logic [3:0] LAST_DAISY = 4'(2 * CHANNELS_PER_DEVICE - 1);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} req_t;

	typedef struct packed {
		logic [3:0]         channel_index;
		logic signed [23:0] sample_value;
		logic [23:0]        device_status;
		logic               frame_last;
	} result_t;

endpackage

@@ src/afd_ifs.sv @@
// ----------------------------------------------------------------------------
// afd channel interfaces
// byte request channel, sample result channel and mode write channel
// ----------------------------------------------------------------------------
interface afd_req_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_start;

	modport source(output valid, data_byte, frame_start, input ready);
	modport sink(input valid, data_byte, frame_start, output ready);
endinterface

interface afd_res_if;
	logic               valid;
	logic               ready;
	logic [3:0]         channel_index;
	logic signed [23:0] sample_value;
	logic [23:0]        device_status;
	logic               frame_last;

	modport source(output valid, channel_index, sample_value, device_status, frame_last,
		input ready);
	modport sink(input valid, channel_index, sample_value, device_status, frame_last,
		output ready);
endinterface

interface afd_cfg_if;
	logic valid;
	logic ready;
	logic daisy_mode;

	modport source(output valid, daisy_mode, input ready);
	modport sink(input valid, daisy_mode, output ready);
endinterface

@@ src/adc_frame_deframer_sign_extend_top.sv @@
// ----------------------------------------------------------------------------
// adc_frame_deframer_sign_extend_top
// Deframes the byte stream of one or two chained 8-channel 24-bit converters.
// Each byte request is taken into an input register and decoded in one pass
// against a section offset, sample phase and channel counter; a completed
// sample leaves through a result register with its channel index, sign
// extended value and device status. One byte request is taken every clock
// while the output is drained; a result left waiting holds the byte in the
// input register and stops further requests until it is taken. A sample's
// last byte is held in the input register, then the result is registered
// on the output. The rate is set by the single decode step between the
// input register and the result register. daisy_mode selects two devices.
// ----------------------------------------------------------------------------
`include "adc_frame_deframer_sign_extend_top_defines.svh"

module adc_frame_deframer_sign_extend_top import afd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	afd_req_if.sink      byte_in,
	afd_res_if.source    result_out,
	afd_cfg_if.sink      cfg
);

	logic               daisy_q;

	logic               valid_s1;
	req_t               req_s1;

	logic               out_valid_q;
	result_t            out_q;

	logic               active_q;
	logic               dev_q;
	logic [OFF_W-1:0]   off_q;
	phase_t             ph_q;
	logic [CH_W-1:0]    ch_q;
	logic [15:0]        partial_q;
	logic [23:0]        status_q;

	logic               advance;
	logic               fire;
	logic               run;
	logic               cur_dev;
	logic [OFF_W-1:0]   cur_off;
	phase_t             cur_ph;
	logic [CH_W-1:0]    cur_ch;
	logic               in_status;
	logic               sec_end;
	logic               frame_end;
	logic               emit;
	result_t            res;

	logic               active_d;
	logic               dev_d;
	logic [OFF_W-1:0]   off_d;
	phase_t             ph_d;
	logic [CH_W-1:0]    ch_d;
	logic [15:0]        partial_d;
	logic [23:0]        status_d;

	// mode register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			daisy_q <= 1'b0;
		end else if (cfg.valid) begin
			daisy_q <= cfg.daisy_mode;
		end
	end

	// input register
	assign advance = !out_valid_q || result_out.ready;
	assign byte_in.ready = !valid_s1 || advance;
	assign fire = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.valid && byte_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			req_s1 <= '{data_byte: byte_in.data_byte, frame_start: byte_in.frame_start};
		end
	end

	// decode
	always_comb begin
		cur_dev = req_s1.frame_start ? 1'b0 : dev_q;
		cur_off = req_s1.frame_start ? '0 : off_q;
		cur_ph = req_s1.frame_start ? PH_HIGH : ph_q;
		cur_ch = req_s1.frame_start ? '0 : ch_q;

		// frame past the single-device length after a mode drop is dead
		run = req_s1.frame_start || (active_q && !(dev_q && !daisy_q));
		in_status = cur_off < OFF_W'(STATUS_BYTES);
		sec_end = cur_off == OFF_W'(SECTION_BYTES - 1);
		frame_end = sec_end && (cur_dev == daisy_q);
		emit = run && !in_status && (cur_ph == PH_LOW);

		res.channel_index = 4'(cur_ch) + (cur_dev ? 4'(CHANNELS_PER_DEVICE) : 4'd0);
		res.sample_value = {partial_q, req_s1.data_byte};
		res.device_status = status_q;
		res.frame_last = (cur_dev == daisy_q) && (cur_ch == CH_W'(CHANNELS_PER_DEVICE - 1));

		active_d = active_q;
		dev_d = dev_q;
		off_d = off_q;
		ph_d = ph_q;
		ch_d = ch_q;
		partial_d = partial_q;
		status_d = status_q;

		if (run) begin
			active_d = !frame_end;
			if (frame_end) begin
				dev_d = 1'b0;
				off_d = '0;
			end else if (sec_end) begin
				dev_d = !cur_dev;
				off_d = '0;
			end else begin
				dev_d = cur_dev;
				off_d = cur_off + OFF_W'(1);
			end

			if (in_status) begin
				status_d = (cur_off == '0) ? {16'd0, req_s1.data_byte}
					: {status_q[15:0], req_s1.data_byte};
				ph_d = PH_HIGH;
				ch_d = '0;
			end else begin
				ch_d = cur_ch;
				case (cur_ph)
					PH_HIGH: begin
						partial_d = {8'd0, req_s1.data_byte};
						ph_d = PH_MID;
					end
					PH_MID: begin
						partial_d = {partial_q[7:0], req_s1.data_byte};
						ph_d = PH_LOW;
					end
					PH_LOW: begin
						ph_d = PH_HIGH;
						ch_d = (cur_ch == CH_W'(CHANNELS_PER_DEVICE - 1)) ? '0
							: cur_ch + CH_W'(1);
					end
					default: begin
						ph_d = PH_HIGH;
					end
				endcase
			end
		end else begin
			active_d = 1'b0;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			dev_q <= 1'b0;
			off_q <= '0;
			ph_q <= PH_HIGH;
			ch_q <= '0;
		end else if (fire) begin
			active_q <= active_d;
			dev_q <= dev_d;
			off_q <= off_d;
			ph_q <= ph_d;
			ch_q <= ch_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			partial_q <= partial_d;
			status_q <= status_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			out_q <= res;
		end
	end

	assign result_out.valid = out_valid_q;
	assign result_out.channel_index = out_q.channel_index;
	assign result_out.sample_value = out_q.sample_value;
	assign result_out.device_status = out_q.device_status;
	assign result_out.frame_last = out_q.frame_last;

	// checks
	`AFD_CHECK(a_last_index, out_valid_q && out_q.frame_last,
		out_q.channel_index == LAST_SINGLE || out_q.channel_index == LAST_DAISY)
	`AFD_CHECK(a_off_range, active_q, off_q < OFF_W'(SECTION_BYTES))
	`AFD_CHECK(a_stall_only, !byte_in.ready, valid_s1 && out_valid_q && !result_out.ready)
	`AFD_CHECK_NEXT(a_emit_shows, fire && emit, out_valid_q)

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives byte requests into the converter frame deframer in single and daisy
// mode and checks every sample result against a cycle-free deframing model.
// A short table covers reset state, sample extremes and a restart mid-frame,
// then random phases of mostly well-formed frames mixed with truncated frames,
// noise and mode changes mid-frame. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
	import afd_pkg::*;

	localparam int LIMIT = 200000;
	localparam int SETTLE = 8;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
		logic       fixed;
		result_t    want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	afd_req_if byte_if();
	afd_res_if res_if();
	afd_cfg_if cfg_if();

	adc_frame_deframer_sign_extend_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_if),
		.result_out (res_if),
		.cfg        (cfg_if)
	);

	// deframing model state
	logic        daisy_r;
	logic        in_frame;
	logic [5:0]  byte_pos;
	logic [15:0] sample_hi;
	logic [23:0] status_acc;

	result_t sample_q[$];

	int  errors;
	int  cycles;
	int  bytes_sent;
	int  frames_started;
	int  samples_seen;
	int  mode_writes;
	bit  no_gaps;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d samples outstanding", cycles, sample_q.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("mismatch at cycle %0d: %s", cycles, msg);
	endtask

	function automatic bit deframe_byte(input logic [7:0] b, input logic s, output result_t r);
		int unsigned devices;
		int unsigned total;
		int unsigned pos;
		int unsigned dev;
		int unsigned off;
		int unsigned k;
		int unsigned ch;
		bit got;
		got = 1'b0;
		r = '0;
		devices = daisy_r ? 2 : 1;
		total = devices * SECTION_BYTES;
		if (s) begin
			in_frame = 1'b1;
			byte_pos = '0;
		end
		if (!in_frame)
			return 1'b0;
		if (byte_pos >= total) begin
			in_frame = 1'b0;
			return 1'b0;
		end
		pos = byte_pos;
		dev = pos / SECTION_BYTES;
		off = pos % SECTION_BYTES;
		if (off < STATUS_BYTES) begin
			status_acc = (off == 0) ? {16'h0000, b} : {status_acc[15:0], b};
		end else begin
			k = off - STATUS_BYTES;
			ch = k / SAMPLE_BYTES;
			case (k % SAMPLE_BYTES)
				PH_HIGH: sample_hi = {8'h00, b};
				PH_MID: sample_hi = {sample_hi[7:0], b};
				default: begin
					r.channel_index = 4'(dev * CHANNELS_PER_DEVICE + ch);
					r.sample_value = {sample_hi, b};
					r.device_status = status_acc;
					r.frame_last = (dev == devices - 1) && (ch == CHANNELS_PER_DEVICE - 1);
					got = 1'b1;
				end
			endcase
		end
		byte_pos = 6'(pos + 1);
		if (pos + 1 >= total) begin
			in_frame = 1'b0;
			byte_pos = '0;
		end
		return got;
	endfunction

	function automatic logic [7:0] pick_byte();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		case (sel)
			0, 1, 2, 3: return 8'h00;
			4, 5, 6, 7: return 8'hFF;
			8, 9, 10: return 8'h80;
			11, 12, 13: return 8'h7F;
			default: return 8'($urandom);
		endcase
	endfunction

	// one byte request, called and left at a falling edge
	task automatic put_byte(input logic [7:0] b, input logic s, input bit fixed,
		input result_t want);
		result_t got;
		bit has;
		while (!no_gaps && $urandom_range(0, 99) < 9) begin
			byte_if.valid <= 1'b0;
			@(negedge clk);
		end
		byte_if.valid <= 1'b1;
		byte_if.data_byte <= b;
		byte_if.frame_start <= s;
		do @(posedge clk); while (!byte_if.ready);
		has = deframe_byte(b, s, got);
		if (fixed)
			sample_q.push_back(want);
		else if (has)
			sample_q.push_back(got);
		bytes_sent++;
		if (s)
			frames_started++;
		@(negedge clk);
	endtask

	task automatic send(input logic [7:0] b, input logic s);
		put_byte(b, s, 1'b0, '0);
	endtask

	task automatic send_frame(input int len);
		send(pick_byte(), 1'b1);
		for (int i = 1; i < len; i++)
			send(pick_byte(), 1'b0);
	endtask

	task automatic drain_results();
		byte_if.valid <= 1'b0;
		while (sample_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_mode(input logic m);
		drain_results();
		cfg_if.valid <= 1'b1;
		cfg_if.daisy_mode <= m;
		do @(posedge clk); while (!cfg_if.ready);
		daisy_r = m;
		mode_writes++;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// result checking
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			samples_seen++;
			if (sample_q.size() == 0) begin
				flag_error($sformatf("unexpected sample ch %0d value %0d status %h last %b",
					res_if.channel_index, res_if.sample_value, res_if.device_status,
					res_if.frame_last));
			end else begin
				want = sample_q.pop_front();
				if (res_if.channel_index !== want.channel_index
					|| res_if.sample_value !== want.sample_value
					|| res_if.device_status !== want.device_status
					|| res_if.frame_last !== want.frame_last)
					flag_error($sformatf({"expected ch %0d value %0d status %h last %b, ",
						"got ch %0d value %0d status %h last %b"},
						want.channel_index, want.sample_value, want.device_status,
						want.frame_last, res_if.channel_index, res_if.sample_value,
						res_if.device_status, res_if.frame_last));
			end
		end
	end

	// result side back-pressure
	initial begin
		res_if.ready <= 1'b0;
		forever begin
			@(negedge clk);
			res_if.ready <= no_gaps || ($urandom_range(0, 99) >= 9);
		end
	end

	initial begin : stimulus
		stim_row_t rows [0:19];
		int unsigned frame_len;
		int unsigned n_frames;
		int unsigned sel;
		int wait_n;
		int phase;

		arst_n <= 1'b0;
		byte_if.valid <= 1'b0;
		byte_if.data_byte <= 8'h00;
		byte_if.frame_start <= 1'b0;
		cfg_if.valid <= 1'b0;
		cfg_if.daisy_mode <= 1'b0;
		errors = 0;
		cycles = 0;
		bytes_sent = 0;
		frames_started = 0;
		samples_seen = 0;
		mode_writes = 0;
		no_gaps = 1'b0;
		daisy_r = 1'b0;
		in_frame = 1'b0;
		byte_pos = '0;
		sample_hi = '0;
		status_acc = '0;

		rows = '{
			'{8'hAB, 1'b0, 1'b0, '0},   // idle byte, ignored
			'{8'hFF, 1'b1, 1'b0, '0},
			'{8'h00, 1'b0, 1'b0, '0},
			'{8'h5A, 1'b0, 1'b0, '0},
			'{8'h80, 1'b0, 1'b0, '0},
			'{8'h00, 1'b0, 1'b0, '0},
			'{8'h00, 1'b0, 1'b1, '{4'd0, -24'sd8388608, 24'hFF005A, 1'b0}},
			'{8'h7F, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b1, '{4'd1, 24'sd8388607, 24'hFF005A, 1'b0}},
			'{8'hFF, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b1, '{4'd2, -24'sd1, 24'hFF005A, 1'b0}},
			'{8'h12, 1'b0, 1'b0, '0},   // partial sample, then restart
			'{8'h00, 1'b1, 1'b0, '0},
			'{8'h00, 1'b0, 1'b0, '0},
			'{8'h00, 1'b0, 1'b0, '0},
			'{8'h00, 1'b0, 1'b0, '0},
			'{8'h00, 1'b0, 1'b0, '0},
			'{8'h01, 1'b0, 1'b1, '{4'd0, 24'sd1, 24'h000000, 1'b0}}
		};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_mode(1'b0);
		foreach (rows[i])
			put_byte(rows[i].data_byte, rows[i].frame_start, rows[i].fixed, rows[i].want);

		phase = 0;
		while (bytes_sent < 1700 || phase < 4) begin
			write_mode(phase % 2 == 0);
			no_gaps = (phase == 2);
			frame_len = daisy_r ? 2 * SECTION_BYTES : SECTION_BYTES;
			// idle bytes, which also end a frame cut short by the mode drop
			repeat ($urandom_range(1, 3))
				send(pick_byte(), 1'b0);
			n_frames = daisy_r ? $urandom_range(2, 4) : $urandom_range(3, 6);
			for (int f = 0; f < n_frames; f++) begin
				sel = $urandom_range(0, 99);
				if (sel < 80) begin
					send_frame(frame_len);
					repeat ($urandom_range(0, 2))
						send(pick_byte(), 1'b0);
				end else if (sel < 92) begin
					send_frame($urandom_range(1, frame_len - 2));
				end else begin
					repeat ($urandom_range(1, 6))
						send(pick_byte(), $urandom_range(0, 7) == 0);
				end
				if (phase == 3 && f == 0)
					drain_results();
			end
			if (daisy_r && $urandom_range(0, 1) == 1)
				send_frame($urandom_range(SECTION_BYTES + 3, 2 * SECTION_BYTES - 4));
			phase++;
		end
		no_gaps = 1'b0;

		byte_if.valid <= 1'b0;
		wait_n = 0;
		while (sample_q.size() != 0 && wait_n < 2000) begin
			@(negedge clk);
			wait_n++;
		end
		repeat (20) @(negedge clk);
		if (sample_q.size() != 0) begin
			$display("%0d expected samples never arrived", sample_q.size());
			errors += sample_q.size();
		end

		$display("sent %0d bytes in %0d frame starts across %0d mode writes", bytes_sent,
			frames_started, mode_writes);
		$display("checked %0d samples, %0d mismatches", samples_seen, errors);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+src
src/afd_pkg.sv
src/afd_ifs.sv
src/adc_frame_deframer_sign_extend_top.sv
sim/tb_top.sv
